// File: src/dis_pkg.sv
// dis_pkg: shared types and constants for the disjoint interval set.
// No dependencies; imported by dis_cell, disjoint_interval_set_top and the testbench.
`default_nettype none

package dis_pkg;

  localparam int MAX_INTERVALS_DEF = 32;
  localparam int VALUE_WIDTH_DEF   = 32;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_DUMP = 1'b1;

  // Compare results latched by each cell for the current add value.
  typedef struct packed {
    logic le;   // valid and start <= value
    logic cov;  // end >= value
    logic jl;   // end + 1 == value
    logic jr;   // start - 1 == value
  } cell_flag_t;

  // Update command from the chain controller to one cell.
  typedef struct packed {
    logic shift_left;   // take the right-hand neighbor's entry
    logic shift_right;  // take the left-hand neighbor's entry
    logic load_new;     // become [value, value]
    logic set_hi_v;     // end := value
    logic set_hi_nb;    // end := right-hand neighbor's end
    logic set_lo_v;     // start := value
  } cell_cmd_t;

endpackage

`default_nettype wire

// File: src/disjoint_interval_set_top.sv
// disjoint_interval_set_top: sorted set of disjoint intervals kept in a cell chain.
// Depends on dis_pkg and dis_cell.
//
//  channel | ports                                          | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid/in_ready, in_cmd, in_value            | beat in
//  out     | out_valid/out_ready, out_interval_start/_end,  | beat out
//          | out_is_empty, out_overflowed, out_last         |
//
// Add: on accept every cell latches its compares against the value; in the ST_ADD
// state the controller decides and shifts/updates the chain in place.
// Dump: one beat per cycle from a read mux over the cells, entry count beats
// (one beat when empty); out_ready low holds it.
// Reset clears all cell valid bits, the overflow flag and the output valid bit.
`default_nettype none

module disjoint_interval_set_top #(
  parameter int MAX_INTERVALS = dis_pkg::MAX_INTERVALS_DEF,
  parameter int VALUE_WIDTH   = dis_pkg::VALUE_WIDTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_cmd,
  input  wire  signed [VALUE_WIDTH-1:0] in_value,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] out_interval_start,
  output logic signed [VALUE_WIDTH-1:0] out_interval_end,
  output logic                         out_is_empty,
  output logic                         out_overflowed,
  output logic                         out_last
);
  import dis_pkg::*;

  localparam int N     = MAX_INTERVALS;
  localparam int IDX_W = $clog2(N);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ADD  = 3'b010,
    ST_DUMP = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;

  logic                   ov_r, ov_nxt;
  logic [VALUE_WIDTH-1:0] os_r, os_nxt, oe_r, oe_nxt;
  logic                   oemp_r, oemp_nxt, oovf_r, oovf_nxt, olast_r, olast_nxt;

  logic                   cmp_en;
  logic [N:0]             vld_ext;
  logic [N:0]             le_ext;
  logic [N-1:0]           cov_v, jl_v, jr_v, left_v, right_v, pos_v;
  logic [VALUE_WIDTH-1:0] lo_a [N];
  logic [VALUE_WIDTH-1:0] hi_a [N];
  cell_flag_t             flag_a [N];
  cell_cmd_t              cmd_a [N];

  logic covered, j_left, j_right, full;
  logic do_merge, do_up, do_dn, do_ins, do_ovf;
  logic [IDX_W:0] idx_inc;
  logic           dump_last;
  logic           out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign cmp_en   = in_valid && in_ready && (in_cmd == CMD_ADD);

  assign vld_ext[N] = 1'b0;
  assign le_ext[N]  = 1'b0;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      logic                   l_vld, r_vld;
      logic [VALUE_WIDTH-1:0] l_lo, l_hi, r_lo, r_hi;

      if (g == 0) begin : g_first
        assign l_vld = 1'b0;
        assign l_lo  = '0;
        assign l_hi  = '0;
      end else begin : g_mid_l
        assign l_vld = vld_ext[g-1];
        assign l_lo  = lo_a[g-1];
        assign l_hi  = hi_a[g-1];
      end
      if (g == N-1) begin : g_last
        assign r_vld = 1'b0;
        assign r_lo  = '0;
        assign r_hi  = '0;
      end else begin : g_mid_r
        assign r_vld = vld_ext[g+1];
        assign r_lo  = lo_a[g+1];
        assign r_hi  = hi_a[g+1];
      end

      dis_cell #(.VALUE_WIDTH(VALUE_WIDTH)) u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmp_en  (cmp_en),
        .cmp_val (in_value),
        .upd_val (value_r),
        .cmd     (cmd_a[g]),
        .l_vld   (l_vld),
        .l_lo    (l_lo),
        .l_hi    (l_hi),
        .r_vld   (r_vld),
        .r_lo    (r_lo),
        .r_hi    (r_hi),
        .vld     (vld_ext[g]),
        .lo      (lo_a[g]),
        .hi      (hi_a[g]),
        .flags   (flag_a[g])
      );

      assign le_ext[g] = flag_a[g].le;
      assign cov_v[g]  = flag_a[g].cov;
      assign jl_v[g]   = flag_a[g].jl;
      assign jr_v[g]   = flag_a[g].jr;

      // le is a thermometer over the sorted chain: cells below the insert point
      assign left_v[g] = le_ext[g] && !le_ext[g+1];
      if (g == 0) begin : g_pos0
        assign pos_v[g] = !le_ext[g];
      end else begin : g_posn
        assign pos_v[g] = !le_ext[g] && le_ext[g-1];
      end
      assign right_v[g] = pos_v[g] && vld_ext[g];

      always_comb begin
        cmd_a[g]             = '0;
        cmd_a[g].shift_left  = do_merge && !le_ext[g];
        cmd_a[g].shift_right = do_ins && !le_ext[g] && !pos_v[g];
        cmd_a[g].load_new    = do_ins && pos_v[g];
        cmd_a[g].set_hi_v    = do_up && left_v[g];
        cmd_a[g].set_hi_nb   = do_merge && left_v[g];
        cmd_a[g].set_lo_v    = do_dn && right_v[g];
      end
    end
  endgenerate

  assign covered = |(left_v & cov_v);
  assign j_left  = |(left_v & jl_v);
  assign j_right = |(right_v & jr_v);
  assign full    = vld_ext[N-1];

  always_comb begin
    do_merge = 1'b0;
    do_up    = 1'b0;
    do_dn    = 1'b0;
    do_ins   = 1'b0;
    do_ovf   = 1'b0;
    if (state_r == ST_ADD && !covered) begin
      do_merge = j_left && j_right;
      do_up    = j_left && !j_right;
      do_dn    = !j_left && j_right;
      do_ins   = !j_left && !j_right && !full;
      do_ovf   = !j_left && !j_right && full;
    end
  end

  assign idx_inc   = {1'b0, idx_r} + (IDX_W+1)'(1);
  assign dump_last = !vld_ext[idx_inc];
  assign out_free  = !ov_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    value_nxt = value_r;
    ovf_nxt   = ovf_r || do_ovf;
    idx_nxt   = idx_r;
    ov_nxt    = ov_r && !out_ready;
    os_nxt    = os_r;
    oe_nxt    = oe_r;
    oemp_nxt  = oemp_r;
    oovf_nxt  = oovf_r;
    olast_nxt = olast_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          idx_nxt = '0;
          if (in_cmd == CMD_ADD) begin
            value_nxt = in_value;
            state_nxt = ST_ADD;
          end else begin
            state_nxt = ST_DUMP;
          end
        end
      end
      ST_ADD: begin
        state_nxt = ST_IDLE;
      end
      ST_DUMP: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          oovf_nxt = ovf_r;
          if (!vld_ext[0]) begin
            os_nxt    = '0;
            oe_nxt    = '0;
            oemp_nxt  = 1'b1;
            olast_nxt = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            os_nxt    = lo_a[idx_r];
            oe_nxt    = hi_a[idx_r];
            oemp_nxt  = 1'b0;
            olast_nxt = dump_last;
            idx_nxt   = idx_inc[IDX_W-1:0];
            if (dump_last) state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    os_r    <= os_nxt;
    oe_r    <= oe_nxt;
    oemp_r  <= oemp_nxt;
    oovf_r  <= oovf_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid          = ov_r;
  assign out_interval_start = os_r;
  assign out_interval_end   = oe_r;
  assign out_is_empty       = oemp_r;
  assign out_overflowed     = oovf_r;
  assign out_last           = olast_r;

endmodule

`default_nettype wire

// File: src/dis_cell.sv
// dis_cell: one entry of the sorted interval chain with its local compares.
// Depends on dis_pkg (cell_flag_t, cell_cmd_t).
`default_nettype none

module dis_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cmp_en,
  input  wire  [VALUE_WIDTH-1:0]       cmp_val,
  input  wire  [VALUE_WIDTH-1:0]       upd_val,
  input  dis_pkg::cell_cmd_t           cmd,
  input  wire                          l_vld,
  input  wire  [VALUE_WIDTH-1:0]       l_lo,
  input  wire  [VALUE_WIDTH-1:0]       l_hi,
  input  wire                          r_vld,
  input  wire  [VALUE_WIDTH-1:0]       r_lo,
  input  wire  [VALUE_WIDTH-1:0]       r_hi,
  output logic                         vld,
  output logic [VALUE_WIDTH-1:0]       lo,
  output logic [VALUE_WIDTH-1:0]       hi,
  output dis_pkg::cell_flag_t          flags
);
  import dis_pkg::*;

  localparam int XW = VALUE_WIDTH + 1;
  localparam logic signed [XW-1:0] ONE_X = 1;

  logic                   vld_r, vld_nxt;
  logic [VALUE_WIDTH-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  cell_flag_t             flags_r, flags_nxt;
  logic signed [XW-1:0]   v_x, lo_x, hi_x;

  // one bit wider so that end + 1 and start - 1 never wrap
  assign v_x  = {cmp_val[VALUE_WIDTH-1], cmp_val};
  assign lo_x = {lo_r[VALUE_WIDTH-1], lo_r};
  assign hi_x = {hi_r[VALUE_WIDTH-1], hi_r};

  always_comb begin
    flags_nxt = flags_r;
    if (cmp_en) begin
      flags_nxt.le  = vld_r && (lo_x <= v_x);
      flags_nxt.cov = (hi_x >= v_x);
      flags_nxt.jl  = ((hi_x + ONE_X) == v_x);
      flags_nxt.jr  = ((lo_x - ONE_X) == v_x);
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    lo_nxt  = lo_r;
    hi_nxt  = hi_r;
    if (cmd.shift_left) begin
      vld_nxt = r_vld;
      lo_nxt  = r_lo;
      hi_nxt  = r_hi;
    end else if (cmd.shift_right) begin
      vld_nxt = l_vld;
      lo_nxt  = l_lo;
      hi_nxt  = l_hi;
    end else if (cmd.load_new) begin
      vld_nxt = 1'b1;
      lo_nxt  = upd_val;
      hi_nxt  = upd_val;
    end else begin
      if (cmd.set_hi_v)  hi_nxt = upd_val;
      if (cmd.set_hi_nb) hi_nxt = r_hi;
      if (cmd.set_lo_v)  lo_nxt = upd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r   <= 1'b0;
      flags_r <= '0;
    end else begin
      vld_r   <= vld_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
  end

  assign vld   = vld_r;
  assign lo    = lo_r;
  assign hi    = hi_r;
  assign flags = flags_r;

endmodule

`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking bench for disjoint_interval_set_top (add/dump over valid-ready).
// Depends on dis_pkg and the RTL under src/; a scoreboard class mirrors the interval store.

module testbench;
  import dis_pkg::*;

  localparam int     VW         = VALUE_WIDTH_DEF;
  localparam int     MAXN       = MAX_INTERVALS_DEF;
  localparam longint VMAX       = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VMIN       = -(longint'(1) <<< (VW - 1));
  localparam int     STALL_CAP  = 2000;
  localparam int     PHASE_SIZE = 66;

  typedef struct {
    logic signed [VW-1:0] lo;
    logic signed [VW-1:0] hi;
    logic                 empty;
    logic                 ovf;
    logic                 last;
  } span_beat_t;

  // Mirrors the interval store and holds the beats each dump should produce.
  class interval_scoreboard;
    longint     span_lo [MAXN];
    longint     span_hi [MAXN];
    int         n_spans;
    bit         ovf;
    span_beat_t dump_q [$];
    int         errors;
    int         adds;
    int         dumps;
    int         beats;
    int         widest;

    function int pending();
      return dump_q.size();
    endfunction

    function void enqueue_beat(span_beat_t b);
      dump_q = {dump_q, b};
    endfunction

    function void merge_value(longint v);
      int  p;
      int  i;
      bit  jl;
      bit  jr;
      p = 0;
      while (p < n_spans && span_lo[p] <= v) p++;
      if (p > 0 && span_hi[p-1] >= v) return;
      // compares run at full 64 bits, so range edges never wrap
      jl = (p > 0) && (span_hi[p-1] + 1 == v);
      jr = (p < n_spans) && (span_lo[p] - 1 == v);
      if (jl && jr) begin
        span_hi[p-1] = span_hi[p];
        for (i = p; i + 1 < n_spans; i++) begin
          span_lo[i] = span_lo[i+1];
          span_hi[i] = span_hi[i+1];
        end
        n_spans--;
      end else if (jl) begin
        span_hi[p-1] = v;
      end else if (jr) begin
        span_lo[p] = v;
      end else if (n_spans >= MAXN) begin
        ovf = 1'b1;
      end else begin
        for (i = n_spans; i > p; i--) begin
          span_lo[i] = span_lo[i-1];
          span_hi[i] = span_hi[i-1];
        end
        span_lo[p] = v;
        span_hi[p] = v;
        n_spans++;
      end
    endfunction

    function void note_input(logic cmd, logic signed [VW-1:0] value);
      span_beat_t b;
      int         k;
      if (cmd == CMD_ADD) begin
        adds++;
        merge_value(longint'(value));
        return;
      end
      dumps++;
      if (n_spans > widest) widest = n_spans;
      if (n_spans == 0) begin
        b.lo = '0;
        b.hi = '0;
        b.empty = 1'b1;
        b.ovf = ovf;
        b.last = 1'b1;
        enqueue_beat(b);
        return;
      end
      for (k = 0; k < n_spans; k++) begin
        b.lo = VW'(span_lo[k]);
        b.hi = VW'(span_hi[k]);
        b.empty = 1'b0;
        b.ovf = ovf;
        b.last = (k == n_spans - 1);
        enqueue_beat(b);
      end
    endfunction

    function void field_check(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(span_beat_t got);
      span_beat_t want;
      if (dump_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got start %0d end %0d empty %0b",
                 $time, got.lo, got.hi, got.empty);
        errors++;
        return;
      end
      want = dump_q.pop_front();
      beats++;
      field_check("interval_start", longint'(want.lo), longint'(got.lo));
      field_check("interval_end", longint'(want.hi), longint'(got.hi));
      field_check("is_empty", longint'(want.empty), longint'(got.empty));
      field_check("overflowed", longint'(want.ovf), longint'(got.ovf));
      field_check("last", longint'(want.last), longint'(got.last));
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_cmd = CMD_ADD;
  logic signed [VW-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW-1:0] out_interval_start;
  logic signed [VW-1:0] out_interval_end;
  logic                 out_is_empty;
  logic                 out_overflowed;
  logic                 out_last;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  interval_scoreboard sb = new();

  disjoint_interval_set_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_cmd             (in_cmd),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_interval_start (out_interval_start),
    .out_interval_end   (out_interval_end),
    .out_is_empty       (out_is_empty),
    .out_overflowed     (out_overflowed),
    .out_last           (out_last)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Beat monitor; all values sampled here are the ones present at the edge.
  always @(posedge clk) begin
    span_beat_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.lo = out_interval_start;
        got.hi = out_interval_end;
        got.empty = out_is_empty;
        got.ovf = out_overflowed;
        got.last = out_last;
        sb.check_result(got);
      end
      if (in_valid && in_ready) sb.note_input(in_cmd, in_value);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_CAP) begin
      $display("%0t: no beat for %0d cycles, %0d beats still due",
               $time, STALL_CAP, sb.pending());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(input logic cmd, input longint v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_value <= VW'(v);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int     send_plan [4];
    int     recv_plan [4];
    int     ph;
    int     j;
    int     r;
    longint base;
    longint width;
    longint off;

    send_plan = '{0, 53, 0, 26};
    recv_plan = '{0, 0, 53, 26};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty dump, range edges, extend both ways, merge, covered values
    send_item(CMD_DUMP, 0);
    send_item(CMD_ADD, VMIN);
    send_item(CMD_ADD, VMAX);
    send_item(CMD_DUMP, 0);
    send_item(CMD_ADD, VMIN + 1);
    send_item(CMD_ADD, VMAX - 1);
    send_item(CMD_ADD, VMAX);
    send_item(CMD_ADD, 10);
    send_item(CMD_ADD, 12);
    send_item(CMD_ADD, 11);
    send_item(CMD_ADD, 11);
    send_item(CMD_ADD, 12);
    send_item(CMD_ADD, 9);
    send_item(CMD_ADD, 13);
    send_item(CMD_ADD, -1);
    send_item(CMD_ADD, 64'sh5555_5555);
    send_item(CMD_ADD, -64'sh5555_5556);
    send_item(CMD_DUMP, 0);
    wait_drained();

    // Each phase sprinkles isolated values over a window, then fills the gaps so
    // that neighbors join and merge; the wide last window runs the store full.
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_plan[ph];
      recv_stall_pct = recv_plan[ph];
      width = (ph == 3) ? 96 : 32;
      base = longint'($signed($urandom));
      if (base > VMAX - width) base = base - width;
      for (j = 0; j < PHASE_SIZE; j++) begin
        r = $urandom_range(99);
        if (r < 15) begin
          send_item(CMD_DUMP, longint'($signed($urandom)));
        end else if (r < 19) begin
          send_item(CMD_ADD, longint'($signed($urandom)));
        end else begin
          if (j < PHASE_SIZE / 2) off = 2 * $urandom_range(width / 2 - 1);
          else off = $urandom_range(width - 1);
          send_item(CMD_ADD, base + off);
        end
      end
      send_item(CMD_DUMP, 0);
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Run covered %0d adds and %0d dumps, %0d interval beats checked.",
             sb.adds, sb.dumps, sb.beats);
    $display("Widest dump held %0d intervals; store overflow %s.",
             sb.widest, sb.ovf ? "reached" : "not reached");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
